[rtl/ps2mct_pkg.sv]
// Shared constants and helper functions for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

	localparam int COORD_BITS = 12;
	localparam int LIM_BITS   = 13;
	localparam int EXT_BITS   = (LIM_BITS > COORD_BITS + 1) ? LIM_BITS : COORD_BITS + 1;
	localparam int SUM_BITS   = COORD_BITS + 2;

	localparam logic [LIM_BITS-1:0] WIDTH_RST  = LIM_BITS'(1024);
	localparam logic [LIM_BITS-1:0] HEIGHT_RST = LIM_BITS'(768);
	localparam logic [COORD_BITS-1:0] CURSOR_X_RST = COORD_BITS'(1024 / 2);
	localparam logic [COORD_BITS-1:0] CURSOR_Y_RST = COORD_BITS'(768 / 2);

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [1:0] POS_FLAG = 2'd0;
	localparam logic [1:0] POS_X    = 2'd1;
	localparam logic [1:0] POS_Y    = 2'd2;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic signed [SUM_BITS-1:0] sum_t;

	// Largest legal coordinate for a limit register: zero acts as one,
	// anything above the coordinate range acts as the full range.
	function automatic coord_t coord_max(input logic [LIM_BITS-1:0] lim);
		logic [EXT_BITS-1:0] l;
		l = EXT_BITS'(lim);
		if (l == '0) begin
			coord_max = '0;
		end else if (l > EXT_BITS'(1 << COORD_BITS)) begin
			coord_max = '1;
		end else begin
			coord_max = COORD_BITS'(l - EXT_BITS'(1));
		end
	endfunction

	// Saturate a moved coordinate to 0..max.
	function automatic coord_t clamp_coord(input sum_t v, input coord_t max_c);
		if (v < 0) begin
			clamp_coord = '0;
		end else if (v > $signed({2'b00, max_c})) begin
			clamp_coord = max_c;
		end else begin
			clamp_coord = COORD_BITS'(v);
		end
	endfunction

endpackage

[rtl/ps2_mouse_packet_cursor_tracker_unit.sv]
// PS/2 mouse three-byte packet decoder with a clamped, tracked cursor.
// A packet's third byte passes the input register, then the result register.
// Throughput: one byte per cycle. While a finished result waits, flag and X bytes still
// advance; the next third byte holds in the input register until the result transfers.
// Reset: byte counter to flag byte, cursor to 512/384, limits to 1024/768, no result pending.
module ps2_mouse_packet_cursor_tracker_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// byte input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               left_pressed,
	output logic                               right_pressed,
	output logic                               middle_pressed,
	output logic                               x_sign_bit,
	output logic                               y_sign_bit,
	output logic                               x_overflow_bit,
	output logic                               y_overflow_bit,
	output logic signed [7:0]                  x_delta,
	output logic signed [7:0]                  y_delta,
	output logic [ps2mct_pkg::COORD_BITS-1:0]  cursor_x_out,
	output logic [ps2mct_pkg::COORD_BITS-1:0]  cursor_y_out,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [ps2mct_pkg::LIM_BITS-1:0]    cfg_data
);

	// Configuration registers
	logic [ps2mct_pkg::LIM_BITS-1:0] width_q;
	logic [ps2mct_pkg::LIM_BITS-1:0] height_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Packet assembly and cursor state
	logic [1:0]          pos_q;
	logic [7:0]          flag_q;
	logic [7:0]          xbyte_q;
	ps2mct_pkg::coord_t  cur_x_q;
	ps2mct_pkg::coord_t  cur_y_q;

	// Result register
	logic                out_valid_q;
	logic [7:0]          res_flag_q;
	logic [7:0]          res_dx_q;
	logic [7:0]          res_dy_q;
	ps2mct_pkg::coord_t  res_x_q;
	ps2mct_pkg::coord_t  res_y_q;

	logic                completes;
	logic                out_free;
	logic                s1_advance;
	logic                in_xfer;
	ps2mct_pkg::sum_t    sum_x;
	ps2mct_pkg::sum_t    sum_y;
	ps2mct_pkg::coord_t  next_x;
	ps2mct_pkg::coord_t  next_y;

	// Registers always writable; user writes only while block is idle, not enforced here.
	assign cfg_ready = 1'b1;

	// A byte in the input stage completes a packet when it is the third one.
	assign completes  = valid_s1 && (pos_q == ps2mct_pkg::POS_Y);
	// Result register can take a new packet when empty or being drained now.
	assign out_free   = !out_valid_q || !out_stall;
	// Flag and X bytes never block; only a finished packet waits on the output.
	assign s1_advance = valid_s1 && (!completes || out_free);
	// Hold the input while its byte cannot move on.
	assign in_stall   = valid_s1 && !s1_advance;
	assign in_xfer    = in_valid && !in_stall;

	// Add X movement, subtract Y movement; each byte sign-extends on its own.
	assign sum_x = $signed({2'b00, cur_x_q})
		+ ps2mct_pkg::SUM_BITS'($signed(xbyte_q));
	assign sum_y = $signed({2'b00, cur_y_q})
		- ps2mct_pkg::SUM_BITS'($signed(byte_s1));
	assign next_x = ps2mct_pkg::clamp_coord(sum_x, ps2mct_pkg::coord_max(width_q));
	assign next_y = ps2mct_pkg::clamp_coord(sum_y, ps2mct_pkg::coord_max(height_q));

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ps2mct_pkg::WIDTH_RST;
			height_q <= ps2mct_pkg::HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ps2mct_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				ps2mct_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: load on every transfer, drain when the byte moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= data_byte;
		end
	end

	// Packet counter, captured bytes and cursor; no sync check on flag bit 3.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= ps2mct_pkg::POS_FLAG;
			flag_q  <= '0;
			xbyte_q <= '0;
			cur_x_q <= ps2mct_pkg::CURSOR_X_RST;
			cur_y_q <= ps2mct_pkg::CURSOR_Y_RST;
		end else if (s1_advance) begin
			case (pos_q)
				ps2mct_pkg::POS_FLAG: begin
					flag_q <= byte_s1;
					pos_q  <= ps2mct_pkg::POS_X;
				end
				ps2mct_pkg::POS_X: begin
					xbyte_q <= byte_s1;
					pos_q   <= ps2mct_pkg::POS_Y;
				end
				default: begin
					cur_x_q <= next_x;
					cur_y_q <= next_y;
					pos_q   <= ps2mct_pkg::POS_FLAG;
				end
			endcase
		end
	end

	// Result register: fill on a completed packet, clear once transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance && completes) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && completes) begin
			res_flag_q <= flag_q;
			res_dx_q   <= xbyte_q;
			res_dy_q   <= byte_s1;
			res_x_q    <= next_x;
			res_y_q    <= next_y;
		end
	end

	// Decode the flag byte straight from the result register.
	assign out_valid      = out_valid_q;
	assign left_pressed   = res_flag_q[0];
	assign right_pressed  = res_flag_q[1];
	assign middle_pressed = res_flag_q[2];
	assign x_sign_bit     = res_flag_q[4];
	assign y_sign_bit     = res_flag_q[5];
	assign x_overflow_bit = res_flag_q[6];
	assign y_overflow_bit = res_flag_q[7];
	assign x_delta        = $signed(res_dx_q);
	assign y_delta        = $signed(res_dy_q);
	assign cursor_x_out   = res_x_q;
	assign cursor_y_out   = res_y_q;

endmodule

[sim/ps2_mouse_packet_cursor_tracker_unit_tb.sv]
// Self-checking testbench for the PS/2 mouse cursor tracker: byte stream in, reports out.
module ps2_mouse_packet_cursor_tracker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// One decoded report as the tracker should present it.
	typedef struct packed {
		logic                left;
		logic                right;
		logic                middle;
		logic                x_sign;
		logic                y_sign;
		logic                x_ovf;
		logic                y_ovf;
		logic [7:0]          dx;
		logic [7:0]          dy;
		ps2mct_pkg::coord_t  cur_x;
		ps2mct_pkg::coord_t  cur_y;
	} mouse_report_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             in_valid  = 1'b0;
	logic                             in_stall;
	logic [7:0]                       data_byte = 8'h00;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             left_pressed;
	logic                             right_pressed;
	logic                             middle_pressed;
	logic                             x_sign_bit;
	logic                             y_sign_bit;
	logic                             x_overflow_bit;
	logic                             y_overflow_bit;
	logic signed [7:0]                x_delta;
	logic signed [7:0]                y_delta;
	ps2mct_pkg::coord_t               cursor_x_out;
	ps2mct_pkg::coord_t               cursor_y_out;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic                             cfg_index = ps2mct_pkg::CFG_WIDTH;
	logic [ps2mct_pkg::LIM_BITS-1:0]  cfg_data  = '0;

	// Bytes still to be offered, and reports owed by the tracker, oldest first.
	logic [7:0]           mouse_bytes[$];
	mouse_report_t        expected_reports[$];

	// Shadow of the tracker: packet position, held bytes, cursor and limits.
	logic [1:0]                       trk_pos  = ps2mct_pkg::POS_FLAG;
	logic [7:0]                       trk_flag = 8'h00;
	logic [7:0]                       trk_xb   = 8'h00;
	ps2mct_pkg::coord_t               trk_x    = ps2mct_pkg::CURSOR_X_RST;
	ps2mct_pkg::coord_t               trk_y    = ps2mct_pkg::CURSOR_Y_RST;
	logic [ps2mct_pkg::LIM_BITS-1:0]  lim_w    = ps2mct_pkg::WIDTH_RST;
	logic [ps2mct_pkg::LIM_BITS-1:0]  lim_h    = ps2mct_pkg::HEIGHT_RST;

	bit                   idle_on  = 1'b1;
	logic                 hold_off = 1'b0;
	int                   send_gap = 0;
	int                   stall_left = 0;
	int                   mismatch_count = 0;

	ps2_mouse_packet_cursor_tracker_unit uut (.*);

	initial forever #5 clk = ~clk;

	// Give up after a generous bound; a healthy run ends far sooner.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Limit register as the tracker applies it: zero acts as one, anything
	// beyond the coordinate range acts as the full range.
	function automatic int usable_limit(input logic [ps2mct_pkg::LIM_BITS-1:0] reg_val);
		int lim;
		lim = int'(reg_val);
		if (lim < 1) lim = 1;
		if (lim > (1 << ps2mct_pkg::COORD_BITS)) lim = 1 << ps2mct_pkg::COORD_BITS;
		return lim;
	endfunction

	function automatic ps2mct_pkg::coord_t saturate(input int v, input int lim);
		int s;
		s = v;
		if (s < 0) s = 0;
		if (s >= lim) s = lim - 1;
		return ps2mct_pkg::coord_t'(s);
	endfunction

	// Advance the shadow by one transferred byte; on the third byte of a
	// packet, move the cursor and queue the report it owes.
	function automatic void track_mouse_byte(input logic [7:0] b);
		mouse_report_t r;
		case (trk_pos)
			ps2mct_pkg::POS_FLAG: begin
				trk_flag = b;
				trk_pos  = ps2mct_pkg::POS_X;
			end
			ps2mct_pkg::POS_X: begin
				trk_xb  = b;
				trk_pos = ps2mct_pkg::POS_Y;
			end
			default: begin
				trk_pos = ps2mct_pkg::POS_FLAG;
				// X moves with the delta, Y against it; the ninth sign bits
				// in the flag byte take no part.
				trk_x = saturate(int'(trk_x) + int'($signed(trk_xb)), usable_limit(lim_w));
				trk_y = saturate(int'(trk_y) - int'($signed(b)), usable_limit(lim_h));
				r.left   = trk_flag[0];
				r.right  = trk_flag[1];
				r.middle = trk_flag[2];
				r.x_sign = trk_flag[4];
				r.y_sign = trk_flag[5];
				r.x_ovf  = trk_flag[6];
				r.y_ovf  = trk_flag[7];
				r.dx     = trk_xb;
				r.dy     = b;
				r.cur_x  = trk_x;
				r.cur_y  = trk_y;
				expected_reports.push_back(r);
			end
		endcase
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Byte driver: predict each transfer, hold a stalled byte, and insert
	// idle bursts only while the channel is free to change.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			data_byte <= 8'h00;
			send_gap  = 0;
		end else begin
			if (in_valid && !in_stall)
				track_mouse_byte(data_byte);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (mouse_bytes.size() == 0) begin
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 11) == 0) begin
					// Start an idle burst; this cycle is its first.
					send_gap = $urandom_range(0, 11);
					in_valid <= 1'b0;
				end else begin
					in_valid  <= 1'b1;
					data_byte <= mouse_bytes.pop_front();
				end
			end
		end
	end

	// Report monitor: compare every transfer with the oldest expectation,
	// then pick the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		mouse_report_t r;
		logic stall_next;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$error("report transferred with no packet outstanding");
					mismatch_count++;
				end else begin
					r = expected_reports.pop_front();
					check_field("left_pressed", r.left, left_pressed);
					check_field("right_pressed", r.right, right_pressed);
					check_field("middle_pressed", r.middle, middle_pressed);
					check_field("x_sign_bit", r.x_sign, x_sign_bit);
					check_field("y_sign_bit", r.y_sign, y_sign_bit);
					check_field("x_overflow_bit", r.x_ovf, x_overflow_bit);
					check_field("y_overflow_bit", r.y_ovf, y_overflow_bit);
					check_field("x_delta", int'($signed(r.dx)), int'(x_delta));
					check_field("y_delta", int'($signed(r.dy)), int'(y_delta));
					check_field("cursor_x_out", int'(r.cur_x), int'(cursor_x_out));
					check_field("cursor_y_out", int'(r.cur_y), int'(cursor_y_out));
				end
			end
			stall_next = hold_off;
			if (stall_left > 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(0, 11);
				stall_next = 1'b1;
			end
			out_stall <= stall_next;
		end
	end

	// Write one limit register and mirror it in the shadow at the same edge.
	task automatic write_limit(input logic idx, input logic [ps2mct_pkg::LIM_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == ps2mct_pkg::CFG_WIDTH)
			lim_w = val;
		else
			lim_h = val;
		cfg_valid <= 1'b0;
	endtask

	// Wait until every byte has transferred and every report has come, then
	// let a trailing partial packet settle inside the tracker.
	task automatic wait_quiet();
		do @(negedge clk);
		while (mouse_bytes.size() != 0 || in_valid || expected_reports.size() != 0 || hold_off);
		repeat (4) @(negedge clk);
	endtask

	function automatic void push_packet(input logic [7:0] f, input logic [7:0] x,
			input logic [7:0] y);
		mouse_bytes.push_back(f);
		mouse_bytes.push_back(x);
		mouse_bytes.push_back(y);
	endfunction

	// Movement byte biased toward full-scale steps in one direction so the
	// cursor runs into both edges of the screen.
	function automatic logic [7:0] move_byte(input bit up);
		case ($urandom_range(0, 7))
			0, 1, 2: move_byte = up ? 8'h7F : 8'h80;
			3:       move_byte = 8'h00;
			4:       move_byte = up ? 8'h01 : 8'hFF;
			default: move_byte = 8'($urandom);
		endcase
	endfunction

	// One phase: set both limits while idle, stream random packets with the
	// odd stray byte to knock the framing out of step, then drain.
	task automatic run_phase(input logic [ps2mct_pkg::LIM_BITS-1:0] w,
			input logic [ps2mct_pkg::LIM_BITS-1:0] h, input int nbytes, input bit squeeze);
		bit up_x;
		bit up_y;
		up_x = $urandom_range(0, 1);
		up_y = $urandom_range(0, 1);
		write_limit(ps2mct_pkg::CFG_WIDTH, w);
		write_limit(ps2mct_pkg::CFG_HEIGHT, h);
		@(negedge clk);
		while (mouse_bytes.size() < nbytes) begin
			if ($urandom_range(0, 29) == 0)
				mouse_bytes.push_back(8'($urandom));
			else
				push_packet(8'($urandom), move_byte(up_x), move_byte(up_y));
		end
		// Hold off the receiver for a long stretch while bytes keep coming,
		// so the tracker fills and stalls its input.
		if (squeeze)
			fork
				begin
					@(posedge clk);
					hold_off <= 1'b1;
					repeat (80) @(posedge clk);
					hold_off <= 1'b0;
				end
			join_none
		wait_quiet();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed packets at the reset limits: every flag bit, zero motion
		// and the full-scale movement values in both directions.
		@(negedge clk);
		push_packet(8'h00, 8'h00, 8'h00);
		push_packet(8'hFF, 8'h7F, 8'h80);
		push_packet(8'h01, 8'h80, 8'h7F);
		push_packet(8'h02, 8'h01, 8'hFF);
		push_packet(8'h04, 8'hFF, 8'h01);
		push_packet(8'h10, 8'h7F, 8'h7F);
		push_packet(8'h20, 8'h80, 8'h80);
		push_packet(8'h40, 8'h00, 8'h80);
		wait_quiet();

		// Zero and oversized limits, each on both axes.
		run_phase(13'd0, 13'd8191, 120, 1'b0);
		run_phase(13'd8191, 13'd0, 120, 1'b0);
		run_phase(13'd4096, 13'd4096, 120, 1'b1);
		// Shrink below the cursor: the next packet must pull it in.
		run_phase(13'd37, 13'd21, 120, 1'b0);
		run_phase(13'd1, 13'd1, 120, 1'b0);
		run_phase(13'd4097, 13'd2, 120, 1'b0);
		run_phase(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), 120, 1'b0);
		run_phase(ps2mct_pkg::WIDTH_RST, ps2mct_pkg::HEIGHT_RST, 120, 1'b0);
		run_phase(13'd3, 13'd5, 120, 1'b0);

		// Closing phase at full rate on both sides.
		@(negedge clk);
		idle_on = 1'b0;
		run_phase(13'd4095, 13'd600, 120, 1'b0);

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
